[hw/rtl/smpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the stable min-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

	localparam int DEPTH = 128;

	localparam int KEY_W = 8;
	localparam int ID_W = 16;
	localparam int STATUS_W = 2;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

	typedef struct packed {
		logic             enq;
		logic             deq;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} cmd_t;

endpackage

[hw/rtl/smpq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: holds a job, shifts right on insert below it,
// shifts left on pop.
// ----------------------------------------------------------------------------
module smpq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  smpq_pkg::cmd_t  cmd,
	input  smpq_pkg::entry_t left,
	input  logic            left_place,
	input  smpq_pkg::entry_t right,
	output smpq_pkg::entry_t entry,
	output logic            place
);

	smpq_pkg::entry_t entry_q;
	smpq_pkg::entry_t nxt;
	logic             load;

	// place: new job belongs at or before this slot
	assign place = !entry_q.valid || (entry_q.key > cmd.key);
	assign entry = entry_q;

	always_comb begin
		nxt  = entry_q;
		load = 1'b0;
		priority if (cmd.enq) begin
			if (place && left_place) begin
				nxt  = left;
				load = 1'b1;
			end else if (place) begin
				nxt.valid = 1'b1;
				nxt.key   = cmd.key;
				nxt.id    = cmd.id;
				load      = 1'b1;
			end
		end else if (cmd.deq) begin
			nxt  = right;
			load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (load) begin
			entry_q <= nxt;
		end
	end

endmodule

[hw/rtl/stable_min_priority_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_min_priority_queue_top
// Bounded min-priority queue as a chain of sorted cells; equal keys leave in
// arrival order.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid/in_stall    func, job_id, num_pages
// out      out_valid/out_stall  status, out_job_id, out_num_pages, is_empty
//
// One transaction per cycle while in_stall is low; each accepted input gives one result in the next cycle.
// All cells compare against the new key in parallel and shift together.
// in_stall follows out_stall only while a result is held in the output reg.
// Reset clears every cell's valid bit; no clearing pass.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [smpq_pkg::ID_W-1:0]     job_id,
	input  logic [smpq_pkg::KEY_W-1:0]    num_pages,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [smpq_pkg::STATUS_W-1:0] status,
	output logic [smpq_pkg::ID_W-1:0]     out_job_id,
	output logic [smpq_pkg::KEY_W-1:0]    out_num_pages,
	output logic                          is_empty
);

	smpq_pkg::entry_t entries [smpq_pkg::DEPTH];
	logic             places  [smpq_pkg::DEPTH];
	smpq_pkg::cmd_t   cmd;
	smpq_pkg::entry_t none;

	logic accept;
	logic full;
	logic empty;

	logic                          out_valid_q;
	logic [smpq_pkg::STATUS_W-1:0] status_q;
	logic [smpq_pkg::ID_W-1:0]     out_job_id_q;
	logic [smpq_pkg::KEY_W-1:0]    out_num_pages_q;
	logic                          is_empty_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = entries[smpq_pkg::DEPTH-1].valid;
	assign empty    = !entries[0].valid;

	assign none = '0;

	assign cmd.enq = accept && (func == smpq_pkg::FUNC_ENQ) && !full;
	assign cmd.deq = accept && (func == smpq_pkg::FUNC_DEQ) && !empty;
	assign cmd.key = num_pages;
	assign cmd.id  = job_id;

	for (genvar i = 0; i < smpq_pkg::DEPTH; i++) begin : g_cell
		smpq_pkg::entry_t lft;
		smpq_pkg::entry_t rgt;
		logic             lft_place;

		if (i == 0) begin : g_first
			assign lft       = none;
			assign lft_place = 1'b0;
		end else begin : g_mid
			assign lft       = entries[i-1];
			assign lft_place = places[i-1];
		end

		if (i == smpq_pkg::DEPTH - 1) begin : g_last
			assign rgt = none;
		end else begin : g_inner
			assign rgt = entries[i+1];
		end

		smpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left       (lft),
			.left_place (lft_place),
			.right      (rgt),
			.entry      (entries[i]),
			.place      (places[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_job_id_q    <= '0;
			out_num_pages_q <= '0;
			if (func == smpq_pkg::FUNC_ENQ) begin
				status_q   <= full ? smpq_pkg::ST_FULL : smpq_pkg::ST_OK;
				is_empty_q <= 1'b0;
			end else if (empty) begin
				status_q   <= smpq_pkg::ST_EMPTY;
				is_empty_q <= 1'b1;
			end else begin
				status_q        <= smpq_pkg::ST_OK;
				out_job_id_q    <= entries[0].id;
				out_num_pages_q <= entries[0].key;
				is_empty_q      <= !entries[1].valid;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign out_job_id    = out_job_id_q;
	assign out_num_pages = out_num_pages_q;
	assign is_empty      = is_empty_q;

endmodule

[hw/rtl/smpq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks for the stable min-priority queue.
// ----------------------------------------------------------------------------
module smpq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [smpq_pkg::STATUS_W-1:0] status,
	input logic [smpq_pkg::ID_W-1:0]     out_job_id,
	input logic [smpq_pkg::KEY_W-1:0]    out_num_pages,
	input logic                          is_empty
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_job_id)
			&& $stable(out_num_pages) && $stable(is_empty))
		else $error("stalled result changed");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == smpq_pkg::ST_FULL) |->
			!is_empty && (out_job_id == '0) && (out_num_pages == '0))
		else $error("full drop with bad fields");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == smpq_pkg::ST_EMPTY) |->
			is_empty && (out_job_id == '0) && (out_num_pages == '0))
		else $error("empty dequeue with bad fields");

	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with no pending result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted transaction gave no result");

endmodule

bind stable_min_priority_queue_top smpq_checker u_smpq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.out_job_id    (out_job_id),
	.out_num_pages (out_num_pages),
	.is_empty      (is_empty)
);
